/* design/hse_pkg.sv */
`timescale 1ns / 1ps
package hse_pkg;

	localparam int BLOCK_BYTES  = 64;
	localparam int DIGEST_BYTES = 20;
	localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;
	localparam int ROUNDS       = 80;

	localparam logic [1:0] ACT_KEY = 2'd0;
	localparam logic [1:0] ACT_MSG = 2'd1;
	localparam logic [1:0] ACT_FIN = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [7:0] PAD_MARK  = 8'h80;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {BLK_BUF, BLK_KEY, BLK_IPAD, BLK_OPAD} blk_sel_t;
	typedef enum logic [1:0] {H_IV, H_CHAIN, H_OUTER} h_sel_t;
	typedef enum logic {DST_CHAIN, DST_OUTER} dst_sel_t;
	typedef enum logic [1:0] {JOB_KEY, JOB_INNER, JOB_OUTER} job_t;

	typedef struct packed {
		logic     latch;
		logic     key_clr;
		logic     key_wr;
		logic     key_digest;
		logic     buf_wr;
		logic     buf_msg;
		logic     buf_pad;
		logic     buf_zero;
		logic     buf_len;
		logic     buf_digest;
		logic     kc_clr;
		logic     kc_inc;
		logic     mc_clr;
		logic     mc_inc;
		logic     comp_start;
		blk_sel_t blk_sel;
		h_sel_t   h_sel;
		dst_sel_t dst_sel;
		job_t     job;
		logic [2:0] emit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic kc_lt64;
		logic kc_eq64;
		logic kc_gt64;
		logic kc_blk_end;
		logic mc_blk_end;
		logic pad_two;
		logic comp_done;
	} dp_stat_t;

	function automatic word_t sha_iv(input logic [2:0] i);
		case (i)
			3'd0:    sha_iv = 32'h67452301;
			3'd1:    sha_iv = 32'hEFCDAB89;
			3'd2:    sha_iv = 32'h98BADCFE;
			3'd3:    sha_iv = 32'h10325476;
			default: sha_iv = 32'hC3D2E1F0;
		endcase
	endfunction

endpackage

/* design/hse_datapath.sv */
`timescale 1ns / 1ps
module hse_datapath import hse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  logic [7:0] data_byte,
	output dp_stat_t stat,
	output logic [31:0] tag_word
);

	word_t key_q [BLOCK_WORDS];
	word_t buf_q [BLOCK_WORDS];
	word_t chain_q [5];
	word_t outer_q [5];
	word_t hbase_q [5];
	word_t v_q [5];
	word_t w_q [BLOCK_WORDS];
	logic [63:0] kc_q, mc_q;
	logic [7:0] byte_q;
	logic [6:0] rnd_q;
	logic run_q, add_q;
	dst_sel_t dst_q;

	word_t blk_w [BLOCK_WORDS];
	word_t hinit [5];
	word_t pad_w [BLOCK_WORDS];
	logic [5:0] fill;
	logic [63:0] len_bits;
	logic [5:0] bidx;
	word_t f, k, t, w_new;

	always_comb begin
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			case (cmd.blk_sel)
				BLK_BUF:  blk_w[i] = cmd.buf_pad ? pad_w[i] : buf_q[i];
				BLK_KEY:  blk_w[i] = key_q[i];
				BLK_IPAD: blk_w[i] = key_q[i] ^ {4{IPAD_BYTE}};
				default:  blk_w[i] = key_q[i] ^ {4{OPAD_BYTE}};
			endcase
		end
		// length words go in with the compression that stores them
		if (cmd.buf_len) begin
			blk_w[BLOCK_WORDS - 2] = len_bits[63:32];
			blk_w[BLOCK_WORDS - 1] = len_bits[31:0];
		end
		for (int j = 0; j < 5; j++) begin
			case (cmd.h_sel)
				H_IV:    hinit[j] = sha_iv(3'(j));
				H_CHAIN: hinit[j] = chain_q[j];
				default: hinit[j] = outer_q[j];
			endcase
		end
	end

	always_comb begin
		case (cmd.job)
			JOB_KEY: begin
				fill     = kc_q[5:0];
				len_bits = {kc_q[60:0], 3'b000};
			end
			JOB_INNER: begin
				fill     = mc_q[5:0];
				len_bits = (mc_q + 64'(BLOCK_BYTES)) << 3;
			end
			default: begin
				fill     = 6'(DIGEST_BYTES);
				len_bits = 64'(BLOCK_BYTES + DIGEST_BYTES) << 3;
			end
		endcase
		bidx = cmd.buf_msg ? mc_q[5:0] : kc_q[5:0];
	end

	// 0x80 at fill, zeros after
	always_comb begin
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			pad_w[i] = buf_q[i];
			for (int l = 0; l < 4; l++) begin
				if (6'(i * 4 + l) == fill)
					pad_w[i][8 * (3 - l) +: 8] = PAD_MARK;
				else if (6'(i * 4 + l) > fill)
					pad_w[i][8 * (3 - l) +: 8] = 8'h00;
			end
		end
	end

	// one SHA-1 round
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k = 32'h8F1BBCDC;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = 32'hCA62C1D6;
		end
		t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			add_q <= 1'b0;
			rnd_q <= '0;
			dst_q <= DST_CHAIN;
			for (int j = 0; j < 5; j++) begin
				chain_q[j] <= sha_iv(3'(j));
				outer_q[j] <= '0;
			end
		end else begin
			add_q <= 1'b0;
			if (cmd.comp_start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
				dst_q <= cmd.dst_sel;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					add_q <= 1'b1;
				end
			end
			if (add_q) begin
				for (int j = 0; j < 5; j++) begin
					if (dst_q == DST_CHAIN)
						chain_q[j] <= hbase_q[j] + v_q[j];
					else
						outer_q[j] <= hbase_q[j] + v_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			for (int i = 0; i < BLOCK_WORDS; i++)
				w_q[i] <= blk_w[i];
			for (int j = 0; j < 5; j++) begin
				v_q[j]     <= hinit[j];
				hbase_q[j] <= hinit[j];
			end
		end else if (run_q) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[BLOCK_WORDS - 1] <= w_new;
			v_q[0] <= t;
			v_q[1] <= v_q[0];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= '0;
			mc_q <= '0;
			for (int i = 0; i < BLOCK_WORDS; i++)
				key_q[i] <= '0;
		end else begin
			if (cmd.kc_clr)
				kc_q <= '0;
			else if (cmd.kc_inc)
				kc_q <= kc_q + 64'd1;
			if (cmd.mc_clr)
				mc_q <= '0;
			else if (cmd.mc_inc)
				mc_q <= mc_q + 64'd1;
			if (cmd.key_clr) begin
				for (int i = 0; i < BLOCK_WORDS; i++)
					key_q[i] <= '0;
			end else if (cmd.key_wr) begin
				key_q[kc_q[5:2]][{~kc_q[1:0], 3'b000} +: 8] <= byte_q;
			end else if (cmd.key_digest) begin
				for (int i = 0; i < BLOCK_WORDS; i++)
					key_q[i] <= (i < 5) ? chain_q[i % 5] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			byte_q <= data_byte;
		if (cmd.buf_wr) begin
			buf_q[bidx[5:2]][{~bidx[1:0], 3'b000} +: 8] <= byte_q;
		end else if (cmd.buf_pad) begin
			for (int i = 0; i < BLOCK_WORDS; i++)
				buf_q[i] <= pad_w[i];
		end else if (cmd.buf_zero) begin
			for (int i = 0; i < BLOCK_WORDS; i++)
				buf_q[i] <= '0;
		end else if (cmd.buf_len) begin
			buf_q[BLOCK_WORDS - 2] <= len_bits[63:32];
			buf_q[BLOCK_WORDS - 1] <= len_bits[31:0];
		end else if (cmd.buf_digest) begin
			for (int j = 0; j < 5; j++)
				buf_q[j] <= chain_q[j];
		end
	end

	always_comb begin
		stat.kc_lt64    = (kc_q[63:6] == '0);
		stat.kc_eq64    = (kc_q == 64'(BLOCK_BYTES));
		stat.kc_gt64    = !stat.kc_lt64 && !stat.kc_eq64;
		stat.kc_blk_end = !stat.kc_lt64 && (kc_q[5:0] == 6'h3f) && !(&kc_q);
		stat.mc_blk_end = (mc_q[5:0] == 6'h3f);
		stat.pad_two    = (fill >= 6'(BLOCK_BYTES - 8));
		stat.comp_done  = add_q;
		case (cmd.emit_idx)
			3'd0:    tag_word = chain_q[0];
			3'd1:    tag_word = chain_q[1];
			3'd2:    tag_word = chain_q[2];
			3'd3:    tag_word = chain_q[3];
			default: tag_word = chain_q[4];
		endcase
	end

endmodule

/* design/hse_ctrl.sv */
`timescale 1ns / 1ps
module hse_ctrl import hse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] action,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output logic     in_ready,
	output logic     out_valid,
	output logic     last_word,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_KCLR, S_KEY, S_BCOMP, S_SETTLE, S_PAD, S_ZERO, S_LEN, S_WAIT,
		S_AFTER, S_KCOPY, S_OPAD, S_IPAD, S_ACT, S_MBYTE, S_DCOPY, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_KEY, PH_MSG, PH_DONE} phase_t;

	state_t state_q, ret_q;
	phase_t phase_q;
	job_t job_q;
	logic [1:0] action_q;
	logic [2:0] idx_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign last_word = (idx_q == 3'd4);

	always_comb begin
		cmd          = '0;
		cmd.job      = job_q;
		cmd.blk_sel  = BLK_BUF;
		cmd.h_sel    = H_CHAIN;
		cmd.dst_sel  = DST_CHAIN;
		cmd.emit_idx = idx_q;
		case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_KCLR: begin
				cmd.key_clr = 1'b1;
				cmd.kc_clr  = 1'b1;
			end
			S_KEY: begin
				cmd.key_wr     = stat.kc_lt64;
				cmd.buf_wr     = !stat.kc_lt64;
				cmd.kc_inc     = 1'b1;
				cmd.comp_start = stat.kc_eq64;
				cmd.blk_sel    = BLK_KEY;
				cmd.h_sel      = H_IV;
			end
			S_BCOMP: cmd.comp_start = 1'b1;
			S_PAD: begin
				cmd.buf_pad    = 1'b1;
				cmd.comp_start = stat.pad_two;
			end
			S_ZERO: cmd.buf_zero = 1'b1;
			S_LEN: begin
				cmd.buf_len    = 1'b1;
				cmd.comp_start = 1'b1;
				cmd.h_sel      = (job_q == JOB_OUTER) ? H_OUTER : H_CHAIN;
			end
			S_KCOPY: cmd.key_digest = 1'b1;
			S_OPAD: begin
				cmd.comp_start = 1'b1;
				cmd.blk_sel    = BLK_OPAD;
				cmd.h_sel      = H_IV;
				cmd.dst_sel    = DST_OUTER;
			end
			S_IPAD: begin
				cmd.comp_start = 1'b1;
				cmd.blk_sel    = BLK_IPAD;
				cmd.h_sel      = H_IV;
				cmd.mc_clr     = 1'b1;
			end
			S_MBYTE: begin
				cmd.buf_wr  = 1'b1;
				cmd.buf_msg = 1'b1;
				cmd.mc_inc  = 1'b1;
			end
			S_DCOPY: cmd.buf_digest = 1'b1;
			S_EMIT: cmd.mc_clr = out_ready && (idx_q == 3'd4);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			phase_q  <= PH_KEY;
			job_q    <= JOB_KEY;
			action_q <= ACT_KEY;
			idx_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q <= action;
						if (action == ACT_KEY)
							state_q <= (phase_q != PH_KEY) ? S_KCLR : S_KEY;
						else if (action == ACT_MSG || action == ACT_FIN) begin
							case (phase_q)
								PH_KEY:  state_q <= S_SETTLE;
								PH_DONE: state_q <= S_IPAD;
								default: state_q <= S_ACT;
							endcase
						end
					end
				end
				S_KCLR: begin
					phase_q <= PH_KEY;
					state_q <= S_KEY;
				end
				S_KEY: begin
					if (stat.kc_eq64) begin
						ret_q   <= S_IDLE;
						state_q <= S_WAIT;
					end else if (stat.kc_blk_end)
						state_q <= S_BCOMP;
					else
						state_q <= S_IDLE;
				end
				S_BCOMP: begin
					ret_q   <= S_IDLE;
					state_q <= S_WAIT;
				end
				S_SETTLE: begin
					if (stat.kc_gt64) begin
						job_q   <= JOB_KEY;
						state_q <= S_PAD;
					end else
						state_q <= S_OPAD;
				end
				S_PAD: begin
					if (stat.pad_two) begin
						ret_q   <= S_ZERO;
						state_q <= S_WAIT;
					end else
						state_q <= S_LEN;
				end
				S_ZERO: state_q <= S_LEN;
				S_LEN: begin
					ret_q   <= S_AFTER;
					state_q <= S_WAIT;
				end
				S_WAIT: if (stat.comp_done) state_q <= ret_q;
				S_AFTER: begin
					case (job_q)
						JOB_KEY:   state_q <= S_KCOPY;
						JOB_INNER: state_q <= S_DCOPY;
						default: begin
							idx_q   <= '0;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_KCOPY: state_q <= S_OPAD;
				S_OPAD: begin
					ret_q   <= S_IPAD;
					state_q <= S_WAIT;
				end
				S_IPAD: begin
					phase_q <= PH_MSG;
					ret_q   <= S_ACT;
					state_q <= S_WAIT;
				end
				S_ACT: begin
					if (action_q == ACT_MSG)
						state_q <= S_MBYTE;
					else begin
						job_q   <= JOB_INNER;
						state_q <= S_PAD;
					end
				end
				S_MBYTE: state_q <= stat.mc_blk_end ? S_BCOMP : S_IDLE;
				S_DCOPY: begin
					job_q   <= JOB_OUTER;
					state_q <= S_PAD;
				end
				S_EMIT: begin
					if (out_ready) begin
						if (idx_q == 3'd4) begin
							phase_q <= PH_DONE;
							state_q <= S_IDLE;
						end else
							idx_q <= idx_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/hmac_sha1_engine.sv */
`timescale 1ns / 1ps
// HMAC-SHA1 engine. Beats go in one at a time: in_ready is high only while the controller
// is idle, so a beat that closes a block, a finish (with padding that may spill into a
// second block), the key settle and a message after a finish all hold off the next beat.
// The pace is set by the controller states per beat and the single round unit (80 rounds
// per block).
// Reset (arst_n low, async): empty key, chaining value at the SHA-1 IV.
module hmac_sha1_engine import hse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] tag_word,
	output logic        last_word
);

	// controller sequences key handling, padding and the inner/outer passes;
	// datapath holds key, block buffer, counters and the round unit
	dp_cmd_t  cmd;
	dp_stat_t stat;

	hse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.last_word (last_word),
		.cmd       (cmd)
	);

	// tag beats come straight from the chaining registers, word by word
	hse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.stat      (stat),
		.tag_word  (tag_word)
	);

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// HMAC-SHA1 engine testbench: queue-fed driver, monitor against a local
// SHA-1/HMAC predictor, random valid/ready idling in three phases.
module testbench;
	import hse_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] tag_word;
	logic        last_word;

	hmac_sha1_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.tag_word(tag_word), .last_word(last_word)
	);

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] data;
	} beat_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} tag_beat_t;

	// sentinel beat: sender holds off until every tag word has come back
	localparam beat_t DRAIN_MARK = '{act: ACT_NOP, data: 8'hff};

	beat_t     pending_beats[$];
	bit        drain_mark[$];
	tag_beat_t expected_tags[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycles;
	bit stim_done;
	bit holding;

	// predictor state
	logic [7:0]  p_key[64];
	logic [63:0] p_kcount;
	word_t       p_chain[5];
	word_t       p_outer[5];
	logic [7:0]  p_buf[64];
	logic [63:0] p_mcount;
	logic [1:0]  p_phase;   // 0 key, 1 message, 2 done

	localparam word_t IV0 = 32'h67452301, IV1 = 32'hEFCDAB89, IV2 = 32'h98BADCFE,
		IV3 = 32'h10325476, IV4 = 32'hC3D2E1F0;

	function automatic word_t rol(word_t x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic sha1_block(ref word_t h[5], input logic [7:0] blk[64]);
		word_t w[80];
		word_t a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endtask

	task automatic load_iv(ref word_t h[5]);
		h[0] = IV0; h[1] = IV1; h[2] = IV2; h[3] = IV3; h[4] = IV4;
	endtask

	// pad the partial block in p_buf and close the hash
	task automatic close_hash(ref word_t h[5], input int fill, input logic [63:0] total);
		logic [63:0] bits;
		bits = total << 3;
		fill = fill & 63;
		p_buf[fill] = PAD_MARK;
		for (int i = fill + 1; i < 64; i++) p_buf[i] = 8'h00;
		if (fill >= 56) begin
			sha1_block(h, p_buf);
			for (int i = 0; i < 64; i++) p_buf[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++) p_buf[63 - i] = bits[8*i +: 8];
		sha1_block(h, p_buf);
	endtask

	task automatic keyed_start(ref word_t h[5], input logic [7:0] pad);
		logic [7:0] blk[64];
		for (int i = 0; i < 64; i++) blk[i] = p_key[i] ^ pad;
		load_iv(h);
		sha1_block(h, blk);
	endtask

	task automatic open_message();
		keyed_start(p_chain, IPAD_BYTE);
		p_mcount = 0;
		p_phase = 2'd1;
	endtask

	task automatic predictor_reset();
		for (int i = 0; i < 64; i++) begin
			p_key[i] = 8'h00; p_buf[i] = 8'h00;
		end
		p_kcount = 0;
		load_iv(p_chain);
		for (int i = 0; i < 5; i++) p_outer[i] = '0;
		p_mcount = 0;
		p_phase = 2'd0;
	endtask

	// one accepted beat into the predictor; finish pushes five tag words
	task automatic predict_hmac(input beat_t bt);
		if (bt.act == ACT_KEY) begin
			if (p_phase != 2'd0) begin
				for (int i = 0; i < 64; i++) p_key[i] = 8'h00;
				p_kcount = 0;
				p_phase = 2'd0;
			end
			if (p_kcount < 64) p_key[p_kcount[5:0]] = bt.data;
			else if (p_kcount == 64) begin
				load_iv(p_chain);
				sha1_block(p_chain, p_key);
				p_buf[0] = bt.data;
			end else p_buf[p_kcount[5:0]] = bt.data;
			p_kcount++;
			if (p_kcount > 64 && p_kcount[5:0] == 0) sha1_block(p_chain, p_buf);
			return;
		end
		if (bt.act == ACT_NOP) return;
		if (p_phase == 2'd0) begin
			// settle the key; long keys collapse to their digest
			if (p_kcount > 64) begin
				close_hash(p_chain, int'(p_kcount[5:0]), p_kcount);
				for (int i = 0; i < 64; i++) p_key[i] = 8'h00;
				for (int i = 0; i < 20; i++)
					p_key[i] = p_chain[i >> 2][(24 - 8*(i & 3)) +: 8];
			end
			keyed_start(p_outer, OPAD_BYTE);
			open_message();
		end else if (p_phase == 2'd2) open_message();
		if (bt.act == ACT_MSG) begin
			p_buf[p_mcount[5:0]] = bt.data;
			p_mcount++;
			if (p_mcount[5:0] == 0) sha1_block(p_chain, p_buf);
			return;
		end
		close_hash(p_chain, int'(p_mcount[5:0]), p_mcount + 64);
		for (int i = 0; i < 20; i++)
			p_buf[i] = p_chain[i >> 2][(24 - 8*(i & 3)) +: 8];
		for (int i = 0; i < 5; i++) p_chain[i] = p_outer[i];
		close_hash(p_chain, 20, 64'd84);
		for (int i = 0; i < 5; i++)
			expected_tags.push_back('{word: p_chain[i], last: (i == 4)});
		p_mcount = 0;
		p_phase = 2'd2;
	endtask

	task automatic add_beat(input logic [1:0] a, input logic [7:0] d);
		pending_beats.push_back('{act: a, data: d});
		drain_mark.push_back(1'b0);
	endtask

	task automatic add_drain();
		pending_beats.push_back(DRAIN_MARK);
		drain_mark.push_back(1'b1);
	endtask

	task automatic add_bytes(input logic [1:0] a, input int n);
		for (int i = 0; i < n; i++) add_beat(a, 8'($urandom_range(0, 255)));
	endtask

	// mostly short keys and messages, now and then a long key or block spill
	task automatic add_random_session();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) add_bytes(ACT_KEY, $urandom_range(65, 140));
		else if (r < 70) add_bytes(ACT_KEY, $urandom_range(1, 20));
		r = $urandom_range(1, 3);
		for (int m = 0; m < r; m++) begin
			if ($urandom_range(0, 9) == 0) add_bytes(ACT_MSG, $urandom_range(50, 70));
			else add_bytes(ACT_MSG, $urandom_range(0, 8));
			if ($urandom_range(0, 19) == 0) add_beat(ACT_NOP, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 14) != 0) add_beat(ACT_FIN, 8'($urandom_range(0, 255)));
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 74;
		stim_done = 1'b0;
		predictor_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: no key, finish after finish, extremes, 64/65 byte keys,
		// ignored action code, key byte mid-message, 55/56 byte padding edges
		add_beat(ACT_FIN, 8'h00);
		add_beat(ACT_FIN, 8'hff);
		add_beat(ACT_KEY, 8'h00);
		add_beat(ACT_KEY, 8'hff);
		add_beat(ACT_MSG, 8'h00);
		add_beat(ACT_NOP, 8'hff);
		add_beat(ACT_MSG, 8'hff);
		add_beat(ACT_FIN, 8'h00);
		add_beat(ACT_MSG, 8'ha5);
		add_beat(ACT_KEY, 8'h5a);
		add_beat(ACT_MSG, 8'h3c);
		add_beat(ACT_FIN, 8'h00);
		add_drain();
		add_bytes(ACT_KEY, 64);
		add_beat(ACT_FIN, 8'h00);
		add_bytes(ACT_KEY, 65);
		add_bytes(ACT_MSG, 55);
		add_beat(ACT_FIN, 8'h00);
		add_bytes(ACT_MSG, 56);
		add_beat(ACT_FIN, 8'h00);

		for (int p = 0; p < 3; p++) begin
			while (pending_beats.size() < ((p == 0) ? 0 : 30)) add_random_session();
			add_beat(ACT_FIN, 8'h00);
			wait (pending_beats.size() == 0);
			if (p == 0) begin
				send_idle_pct = 74; recv_idle_pct = 11;
			end else if (p == 1) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
		end
		stim_done = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			action    <= ACT_KEY;
			data_byte <= 8'h00;
			holding   <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_hmac('{act: action, data: data_byte});
			if (!in_valid || in_ready) begin
				if (holding) begin
					in_valid <= 1'b0;
					if (expected_tags.size() == 0) holding <= 1'b0;
				end else if (pending_beats.size() != 0 && drain_mark[0]) begin
					void'(pending_beats.pop_front());
					void'(drain_mark.pop_front());
					holding  <= 1'b1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
					action    <= pending_beats[0].act;
					data_byte <= pending_beats[0].data;
					in_valid  <= 1'b1;
					void'(pending_beats.pop_front());
					void'(drain_mark.pop_front());
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			mismatches <= 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (expected_tags.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected tag beat: word %h last %b", tag_word, last_word);
					mismatches <= mismatches + 1;
				end else begin
					if (expected_tags[0].word !== tag_word || expected_tags[0].last !== last_word) begin
						if (mismatches < 10)
							$display("tag mismatch: expected %h/%b got %h/%b",
								expected_tags[0].word, expected_tags[0].last, tag_word, last_word);
						mismatches <= mismatches + 1;
					end
					void'(expected_tags.pop_front());
				end
			end
		end
	end

	// timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		@(posedge clk);
		wait (!in_valid && expected_tags.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_tags.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
